FILE: hdl/tcpp_pkg.sv
// Package for the TLV control packet parser.
// Holds the channel word types, the parser state encodings and the register indexes.
// No dependencies.
package tcpp_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned SizeW = 31;
  localparam int unsigned CfgIdxW = 8;
  localparam logic [SizeW-1:0] SizeMax = {SizeW{1'b1}};

  localparam logic [CfgIdxW-1:0] CFG_SIZE_TYPE = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_NAME_TYPE = 8'd1;

  localparam logic [ByteW-1:0] SIZE_TYPE_RST = 8'd0;
  localparam logic [ByteW-1:0] NAME_TYPE_RST = 8'd1;

  localparam logic [ByteW-1:0] ASCII_ZERO = 8'h30;
  localparam logic [ByteW-1:0] ASCII_NINE = 8'h39;

  typedef enum logic [1:0] {
    PH_CTRL = 2'd0,
    PH_TYPE = 2'd1,
    PH_LEN  = 2'd2,
    PH_VAL  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_SIZE    = 2'd1,
    KIND_NAME    = 2'd2,
    KIND_UNKNOWN = 2'd3
  } kind_t;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             end_of_packet;
  } in_word_t;

  typedef struct packed {
    logic             name_valid;
    logic [ByteW-1:0] name_char;
    logic             packet_done;
    logic [SizeW-1:0] file_size;
    logic             parse_error;
  } out_word_t;

endpackage

FILE: hdl/tlv_control_packet_parser.sv
// Top level of the TLV control packet parser.
// Depends on tcpp_pkg.
//
// Takes one packet byte per cycle while in_stall is low and returns exactly one result word
// per accepted byte. The first byte of a packet is a control byte and is skipped; after it
// come type, length and value bytes. Size values are parsed as decimal ASCII and saturate
// at 2^31-1; name value bytes come out one per result word. The last byte of a packet reports
// the size (0 on error) and the error flag. A two-entry output buffer keeps input flowing
// while one result waits; in_stall rises only when both output entries are full. The user
// must write the two type codes through the cfg port (index 0 size, index 1 name) while the
// block is idle; the block itself does not enforce this.
module tlv_control_packet_parser (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  tcpp_pkg::in_word_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output tcpp_pkg::out_word_t           out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tcpp_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [tcpp_pkg::ByteW-1:0]    cfg_data
);
  import tcpp_pkg::*;

  logic [ByteW-1:0] size_type_r, name_type_r;
  phase_t           phase_r, phase_nxt;
  kind_t            kind_r, kind_nxt;
  logic [ByteW-1:0] left_r, left_nxt;
  logic [SizeW-1:0] acc_r, acc_nxt;
  logic             stopped_r, stopped_nxt;
  logic             err_r, err_nxt;

  out_word_t        main_r, skid_r, res;
  logic             main_vld_r, skid_vld_r;
  logic             in_fire;

  logic [SizeW+3:0] acc_x10;
  logic             is_digit, trunc, bad;
  logic [ByteW-1:0] b;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_vld_r;
  assign in_fire   = in_valid && !in_stall;
  assign out_valid = main_vld_r;
  assign out_data  = main_r;
  assign b         = in_data.data_byte;

  assign is_digit = (b >= ASCII_ZERO) && (b <= ASCII_NINE);
  assign acc_x10  = {3'b000, acc_r, 1'b0} + {1'b0, acc_r, 3'b000}
                  + {{(SizeW+4-ByteW){1'b0}}, b - ASCII_ZERO};

  always_comb begin
    phase_nxt   = phase_r;
    kind_nxt    = kind_r;
    left_nxt    = left_r;
    acc_nxt     = acc_r;
    stopped_nxt = stopped_r;
    err_nxt     = err_r;
    res         = '0;
    trunc       = 1'b0;
    if (!err_r) begin
      case (phase_r)
        PH_CTRL: phase_nxt = PH_TYPE;
        PH_TYPE: begin
          if (b == size_type_r) begin
            kind_nxt    = KIND_SIZE;
            acc_nxt     = '0;
            stopped_nxt = 1'b0;
            phase_nxt   = PH_LEN;
          end else if (b == name_type_r) begin
            kind_nxt  = KIND_NAME;
            phase_nxt = PH_LEN;
          end else begin
            kind_nxt = KIND_UNKNOWN;
            err_nxt  = 1'b1;
          end
        end
        PH_LEN: begin
          left_nxt  = b;
          phase_nxt = (b == '0) ? PH_TYPE : PH_VAL;
        end
        default: begin
          if (kind_r == KIND_SIZE) begin
            if (!stopped_r) begin
              if (!is_digit) begin
                stopped_nxt = 1'b1;
              end else if (acc_x10 > {4'b0000, SizeMax}) begin
                acc_nxt = SizeMax;
              end else begin
                acc_nxt = acc_x10[SizeW-1:0];
              end
            end
          end else if (kind_r == KIND_NAME) begin
            res.name_valid = 1'b1;
            res.name_char  = b;
          end
          left_nxt = left_r - 1'b1;
          if (left_nxt == '0) phase_nxt = PH_TYPE;
        end
      endcase
      trunc = in_data.end_of_packet && (phase_nxt == PH_LEN || phase_nxt == PH_VAL);
    end
    bad = trunc || err_nxt;
    if (in_data.end_of_packet) begin
      res.packet_done = 1'b1;
      res.parse_error = bad;
      res.file_size   = bad ? '0 : acc_nxt;
      phase_nxt       = PH_CTRL;
      kind_nxt        = KIND_NONE;
      left_nxt        = '0;
      acc_nxt         = '0;
      stopped_nxt     = 1'b0;
      err_nxt         = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_type_r <= SIZE_TYPE_RST;
      name_type_r <= NAME_TYPE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SIZE_TYPE: size_type_r <= cfg_data;
        CFG_NAME_TYPE: name_type_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_CTRL;
      kind_r    <= KIND_NONE;
      left_r    <= '0;
      acc_r     <= '0;
      stopped_r <= 1'b0;
      err_r     <= 1'b0;
    end else if (in_fire) begin
      phase_r   <= phase_nxt;
      kind_r    <= kind_nxt;
      left_r    <= left_nxt;
      acc_r     <= acc_nxt;
      stopped_r <= stopped_nxt;
      err_r     <= err_nxt;
    end
  end

  // two-entry output buffer: main drives the port, skid catches a word during a stall
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (!main_vld_r || !out_stall) begin
      if (skid_vld_r) begin
        main_vld_r <= 1'b1;
        skid_vld_r <= 1'b0;
      end else begin
        main_vld_r <= in_fire;
      end
    end else if (in_fire) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_vld_r || !out_stall) begin
      main_r <= skid_vld_r ? skid_r : res;
    end else if (in_fire) begin
      skid_r <= res;
    end
  end

endmodule

FILE: hdl/tcpp_checker.sv
// Port-level checker for the TLV control packet parser, with its bind statement.
// Depends on tcpp_pkg and tlv_control_packet_parser.
module tcpp_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input tcpp_pkg::out_word_t           out_data
);
  import tcpp_pkg::*;

  a_stall_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no result word pending");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result word changed");

  a_mid_packet_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.packet_done |-> out_data.file_size == '0 && !out_data.parse_error)
    else $error("size or error reported before packet end");

  a_error_zero_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.parse_error |-> out_data.file_size == '0)
    else $error("nonzero size on errored packet");

  a_name_char_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.name_valid |-> out_data.name_char == '0)
    else $error("name_char set without name_valid");

endmodule

bind tlv_control_packet_parser tcpp_checker u_tcpp_checker (.*);
